/* hw/rtl/frls_pkg.sv */
// ----------------------------------------------------------------------------
// frls_pkg
// Shared types and constants of the flash record log store.
// ----------------------------------------------------------------------------
`default_nettype none

package frls_pkg;

  localparam logic [7:0] BLANK_ID  = 8'hFF;
  localparam logic [5:0] STAGE_MAX = 6'd63;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_UNCHANGED = 3'd1,
    ST_READ      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CK,
    S_RD_RD,
    S_RD_EMIT,
    S_CMP_RD,
    S_CMP_CK,
    S_AP_CHK,
    S_AP_ID,
    S_AP_RD,
    S_AP_WR,
    S_CP_NEXT,
    S_CP_ID_RD,
    S_CP_ID_CK,
    S_CP_K_RD,
    S_CP_K_CK,
    S_CP_CP_RD,
    S_CP_CP_WR,
    S_CP_RS_RD,
    S_CP_RS_WR,
    S_CP_DONE,
    S_EMIT
  } state_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] record_id;
    logic [7:0] byte_value;
    logic [5:0] record_size;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/frls_stage.sv */
// ----------------------------------------------------------------------------
// frls_stage
// Staging buffer for record bytes: 64-entry memory and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire logic [7:0] wr_data_i,
  input  wire logic       clr_i,
  input  wire logic [5:0] rd_addr_i,
  output logic [7:0]      rd_data_o,
  output logic [5:0]      count_o
);
  import frls_pkg::*;

  logic [7:0] mem [64];
  logic [5:0] count_q, count_d;
  logic       room;

  assign room = (count_q < STAGE_MAX);

  always_comb begin
    count_d = count_q;
    if (wr_en_i && room) count_d = count_q + 6'd1;
    if (clr_i) count_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && room) mem[count_q] <= wr_data_i;
    rd_data_o <= mem[rd_addr_i];
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

/* hw/rtl/frls_core.sv */
// ----------------------------------------------------------------------------
// frls_core
// Page store and compaction memories with the commit, read and compaction
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_core #(
  parameter int PAGE_COUNT = 64,
  parameter int PAGE_BYTES = 64,
  parameter int MAX_KEPT   = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  frls_pkg::item_t     item_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output frls_pkg::res_t      res_o
);
  import frls_pkg::*;

  localparam int PG_W  = $clog2(PAGE_COUNT);
  localparam int PGC_W = $clog2(PAGE_COUNT + 1);
  localparam int PB_W  = $clog2(PAGE_BYTES);
  localparam int KW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KC_W  = $clog2(MAX_KEPT + 1);
  localparam int CW    = ((PB_W > 6) ? PB_W : 6) + 1;
  localparam int PA_W  = PG_W + PB_W;
  localparam int KA_W  = KW + PB_W;
  localparam int PDEPTH = PAGE_COUNT << PB_W;
  localparam int KDEPTH = (1 << KW) << PB_W;

  logic [7:0] page_mem [PDEPTH];
  logic [7:0] kept_mem [KDEPTH];

  state_e            state_q, state_d;
  logic [PGC_W-1:0]  nb_q, nb_d;
  logic [PGC_W-1:0]  pcnt_q, pcnt_d;
  logic [PG_W-1:0]   page_q, page_d;
  logic [PB_W-1:0]   bcnt_q, bcnt_d;
  logic [KC_W-1:0]   kcnt_q, kcnt_d;
  logic [KC_W-1:0]   used_q, used_d;
  logic [7:0]        id_q, id_d;
  logic [7:0]        cid_q, cid_d;
  logic [5:0]        len_q, len_d;
  logic [5:0]        cnt_q, cnt_d;
  action_e           act_q, act_d;
  status_e           rst_q, rst_d;

  logic              pr_en, pw_en, kw_en;
  logic [PA_W-1:0]   pr_addr, pw_addr;
  logic [KA_W-1:0]   kr_addr, kw_addr;
  logic [7:0]        pw_data, kw_data;
  logic [7:0]        prd_q, krd_q, srd;
  logic [5:0]        s_addr, s_count;
  logic              s_wr, s_clr, accept;

  logic [5:0]        len_in, size_nz;
  logic [5:0]        cnt_in;
  logic [PG_W-1:0]   pm1;
  logic              b_last_len, b_lt_len, b_lt_cnt, b_last_page;
  logic [7:0]        rec_b;

  assign accept = in_valid_i && in_ready_o;
  assign s_wr   = accept && (item_i.action == ACT_WRITE);
  assign s_clr  = s_wr && item_i.last_byte;

  frls_stage u_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s_wr),
    .wr_data_i (item_i.byte_value),
    .clr_i     (s_clr),
    .rd_addr_i (s_addr),
    .rd_data_o (srd),
    .count_o   (s_count)
  );

  // effective length and count after this beat is staged
  assign size_nz = (item_i.record_size == 6'd0) ? 6'd1 : item_i.record_size;
  assign len_in  = (CW'(size_nz) > CW'(PAGE_BYTES - 1)) ? 6'(PAGE_BYTES - 1) : size_nz;
  assign cnt_in  = (s_count < STAGE_MAX) ? s_count + 6'd1 : s_count;

  assign pm1         = PG_W'(pcnt_q - 1'b1);
  assign b_last_len  = (CW'(bcnt_q) + CW'(1)) == CW'(len_q);
  assign b_lt_len    = CW'(bcnt_q) < CW'(len_q);
  assign b_lt_cnt    = CW'(bcnt_q) < CW'(cnt_q);
  assign b_last_page = (CW'(bcnt_q) + CW'(1)) == CW'(PAGE_BYTES - 1);
  assign rec_b       = (b_lt_len && b_lt_cnt) ? srd : BLANK_ID;

  // next state and counters
  always_comb begin
    state_d = state_q;
    nb_d    = nb_q;
    pcnt_d  = pcnt_q;
    page_d  = page_q;
    bcnt_d  = bcnt_q;
    kcnt_d  = kcnt_q;
    used_d  = used_q;
    id_d    = id_q;
    cid_d   = cid_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    rst_d   = rst_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d   = item_i.record_id;
          len_d  = len_in;
          cnt_d  = cnt_in;
          act_d  = item_i.action;
          pcnt_d = nb_q;
          bcnt_d = '0;
          if (item_i.action == ACT_READ) begin
            if (item_i.record_id == BLANK_ID || nb_q == '0) begin
              rst_d   = ST_NOT_FOUND;
              state_d = S_EMIT;
            end else begin
              state_d = S_FIND_RD;
            end
          end else if (item_i.last_byte) begin
            if (item_i.record_id == BLANK_ID) begin
              rst_d   = ST_NOT_FOUND;
              state_d = S_EMIT;
            end else if (nb_q == '0) begin
              state_d = S_AP_CHK;
            end else begin
              state_d = S_FIND_RD;
            end
          end
        end
      end
      S_FIND_RD: state_d = S_FIND_CK;
      S_FIND_CK: begin
        if (prd_q == id_q) begin
          page_d  = pm1;
          bcnt_d  = '0;
          state_d = (act_q == ACT_READ) ? S_RD_RD : S_CMP_RD;
        end else if (pcnt_q == PGC_W'(1)) begin
          if (act_q == ACT_READ) begin
            rst_d   = ST_NOT_FOUND;
            state_d = S_EMIT;
          end else begin
            state_d = S_AP_CHK;
          end
        end else begin
          pcnt_d  = pcnt_q - 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_RD_RD: state_d = S_RD_EMIT;
      S_RD_EMIT: begin
        if (res_ready_i) begin
          if (b_last_len) begin
            state_d = S_IDLE;
          end else begin
            bcnt_d  = bcnt_q + 1'b1;
            state_d = S_RD_RD;
          end
        end
      end
      S_CMP_RD: state_d = S_CMP_CK;
      S_CMP_CK: begin
        if (prd_q != (b_lt_cnt ? srd : BLANK_ID)) begin
          state_d = S_AP_CHK;
        end else if (b_last_len) begin
          rst_d   = ST_UNCHANGED;
          state_d = S_EMIT;
        end else begin
          bcnt_d  = bcnt_q + 1'b1;
          state_d = S_CMP_RD;
        end
      end
      S_AP_CHK: begin
        bcnt_d = '0;
        if (nb_q == PGC_W'(PAGE_COUNT)) begin
          pcnt_d  = PGC_W'(PAGE_COUNT);
          used_d  = '0;
          state_d = S_CP_NEXT;
        end else begin
          state_d = S_AP_ID;
        end
      end
      S_AP_ID: state_d = S_AP_RD;
      S_AP_RD: state_d = S_AP_WR;
      S_AP_WR: begin
        if (b_last_page) begin
          nb_d    = nb_q + 1'b1;
          rst_d   = ST_WRITTEN;
          state_d = S_EMIT;
        end else begin
          bcnt_d  = bcnt_q + 1'b1;
          state_d = S_AP_RD;
        end
      end
      S_CP_NEXT: begin
        kcnt_d = '0;
        bcnt_d = '0;
        if (pcnt_q == '0 || used_q == KC_W'(MAX_KEPT)) begin
          state_d = (used_q == '0) ? S_CP_DONE : S_CP_RS_RD;
        end else begin
          state_d = S_CP_ID_RD;
        end
      end
      S_CP_ID_RD: state_d = S_CP_ID_CK;
      S_CP_ID_CK: begin
        cid_d  = prd_q;
        kcnt_d = '0;
        bcnt_d = '0;
        if (prd_q == BLANK_ID) begin
          pcnt_d  = pcnt_q - 1'b1;
          state_d = S_CP_NEXT;
        end else begin
          state_d = (used_q == '0) ? S_CP_CP_RD : S_CP_K_RD;
        end
      end
      S_CP_K_RD: state_d = S_CP_K_CK;
      S_CP_K_CK: begin
        if (krd_q == cid_q) begin
          pcnt_d  = pcnt_q - 1'b1;
          state_d = S_CP_NEXT;
        end else if (kcnt_q + 1'b1 == used_q) begin
          bcnt_d  = '0;
          state_d = S_CP_CP_RD;
        end else begin
          kcnt_d  = kcnt_q + 1'b1;
          state_d = S_CP_K_RD;
        end
      end
      S_CP_CP_RD: state_d = S_CP_CP_WR;
      S_CP_CP_WR: begin
        if (CW'(bcnt_q) == CW'(PAGE_BYTES - 1)) begin
          used_d  = used_q + 1'b1;
          pcnt_d  = pcnt_q - 1'b1;
          state_d = S_CP_NEXT;
        end else begin
          bcnt_d  = bcnt_q + 1'b1;
          state_d = S_CP_CP_RD;
        end
      end
      S_CP_RS_RD: state_d = S_CP_RS_WR;
      S_CP_RS_WR: begin
        if (CW'(bcnt_q) == CW'(PAGE_BYTES - 1)) begin
          bcnt_d = '0;
          if (kcnt_q + 1'b1 == used_q) begin
            state_d = S_CP_DONE;
          end else begin
            kcnt_d  = kcnt_q + 1'b1;
            state_d = S_CP_RS_RD;
          end
        end else begin
          bcnt_d  = bcnt_q + 1'b1;
          state_d = S_CP_RS_RD;
        end
      end
      S_CP_DONE: begin
        nb_d   = PGC_W'(used_q);
        bcnt_d = '0;
        if ((PGC_W + KC_W)'(used_q) == (PGC_W + KC_W)'(PAGE_COUNT)) begin
          rst_d   = ST_FULL;
          state_d = S_EMIT;
        end else begin
          state_d = S_AP_ID;
        end
      end
      S_EMIT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_WRITTEN, data: 8'd0, last: 1'b1};
    pr_en       = 1'b1;
    pr_addr     = '0;
    pw_en       = 1'b0;
    pw_addr     = {PG_W'(nb_q), PB_W'(0)};
    pw_data     = id_q;
    kr_addr     = '0;
    kw_en       = 1'b0;
    kw_addr     = {used_q[KW-1:0], bcnt_q};
    kw_data     = prd_q;
    s_addr      = 6'(bcnt_q);
    unique case (state_q)
      S_IDLE:     in_ready_o = 1'b1;
      S_FIND_RD:  pr_addr = {pm1, PB_W'(0)};
      S_RD_RD:    pr_addr = {page_q, bcnt_q + 1'b1};
      S_RD_EMIT: begin
        pr_en       = 1'b0;
        res_valid_o = 1'b1;
        res_o       = '{status: ST_READ, data: prd_q, last: b_last_len};
      end
      S_CMP_RD:   pr_addr = {page_q, bcnt_q + 1'b1};
      S_AP_ID:    pw_en = 1'b1;
      S_AP_WR: begin
        pw_en   = 1'b1;
        pw_addr = {PG_W'(nb_q), bcnt_q + 1'b1};
        pw_data = rec_b;
      end
      S_CP_ID_RD: pr_addr = {pm1, PB_W'(0)};
      S_CP_K_RD:  kr_addr = {kcnt_q[KW-1:0], PB_W'(0)};
      S_CP_CP_RD: pr_addr = {pm1, bcnt_q};
      S_CP_CP_WR: kw_en = 1'b1;
      S_CP_RS_RD: kr_addr = {kcnt_q[KW-1:0], bcnt_q};
      S_CP_RS_WR: begin
        pw_en   = 1'b1;
        pw_addr = {PG_W'(kcnt_q), bcnt_q};
        pw_data = krd_q;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        res_o       = '{status: rst_q, data: 8'd0, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nb_q    <= '0;
      pcnt_q  <= '0;
      bcnt_q  <= '0;
      kcnt_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      nb_q    <= nb_d;
      pcnt_q  <= pcnt_d;
      bcnt_q  <= bcnt_d;
      kcnt_q  <= kcnt_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    id_q   <= id_d;
    cid_q  <= cid_d;
    len_q  <= len_d;
    cnt_q  <= cnt_d;
    act_q  <= act_d;
    rst_q  <= rst_d;
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) page_mem[pw_addr] <= pw_data;
    if (pr_en) prd_q <= page_mem[pr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (kw_en) kept_mem[kw_addr] <= kw_data;
    krd_q <= kept_mem[kr_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/flash_record_log_store.sv */
// A non-final write beat is staged in idle; the next beat may follow at once.
// A commit scans pages, newest first, for the last copy of the id, compares its
// bytes and appends a new page if they differ; a read emits one byte per beat.
// Compaction, on a full store, keeps the newest copy of up to MAX_KEPT ids and
// copies them back; no new item is taken until the result is handed on.
// Reset is asynchronous and active low; no clearing pass, pages above the fill
// count are never read.
// ----------------------------------------------------------------------------
// flash_record_log_store
// Keyed record log over an erasable page store with staging and compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_record_log_store #(
  parameter int PAGE_COUNT = 64,
  parameter int PAGE_BYTES = 64,
  parameter int MAX_KEPT   = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       action_i,
  input  wire logic [7:0] record_id_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [5:0] record_size_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o
);
  import frls_pkg::*;

  item_t item;
  res_t  res, out_q;
  logic  in_ready, res_valid, res_ready;
  logic  out_valid_q, out_valid_d;

  assign item = '{action: action_e'(action_i), record_id: record_id_i,
                  byte_value: byte_value_i, record_size: record_size_i,
                  last_byte: last_byte_i};

  frls_core #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_KEPT   (MAX_KEPT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output beat register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    if (res_valid && res_ready) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign data_byte_o = out_q.data;
  assign last_o      = out_q.last;

endmodule

`default_nettype wire
